// ===== rtl/utf8_encoder_six_byte_top_assert.svh =====
// Assertion macros for the six-byte UTF-8 encoder.
// Included by the top level; expects clk and rst_n in scope.
`ifndef UTF8_ENCODER_SIX_BYTE_TOP_ASSERT_SVH
`define UTF8_ENCODER_SIX_BYTE_TOP_ASSERT_SVH
`ifndef SYNTH
`define U8E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8e assertion failed");
`define U8E_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8e assertion failed");
`else
`define U8E_ASSERT_IMP(lbl, ante, cons)
`define U8E_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/u8e_pkg.sv =====
// Shared types and constants of the six-byte UTF-8 encoder.
// No dependencies; imported by every module of the block.
package u8e_pkg;

    localparam int MAX_BYTES = 6;
    localparam int SEQ_W     = MAX_BYTES * 8;

    typedef logic [2:0] len_t;

    localparam len_t LEN1 = 3'd1;
    localparam len_t LEN2 = 3'd2;
    localparam len_t LEN3 = 3'd3;
    localparam len_t LEN4 = 3'd4;
    localparam len_t LEN5 = 3'd5;
    localparam len_t LEN6 = 3'd6;

    localparam logic [31:0] MAX_LEN1 = 32'h0000_007f;
    localparam logic [31:0] MAX_LEN2 = 32'h0000_07ff;
    localparam logic [31:0] MAX_LEN3 = 32'h0000_ffff;
    localparam logic [31:0] MAX_LEN4 = 32'h001f_ffff;
    localparam logic [31:0] MAX_LEN5 = 32'h03ff_ffff;

    localparam logic [7:0] LEAD2      = 8'hc0;
    localparam logic [7:0] LEAD3      = 8'he0;
    localparam logic [7:0] LEAD4      = 8'hf0;
    localparam logic [7:0] LEAD5      = 8'hf8;
    localparam logic [7:0] LEAD6      = 8'hfc;
    localparam logic [1:0] CONT_MARK  = 2'b10;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    typedef struct packed {
        logic [30:0] cp;
        len_t        len;
        logic        space;
    } char_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        len_t             len;
    } seq_t;

endpackage

// ===== rtl/utf8_encoder_six_byte_top.sv =====
// Six-byte (RFC 2279) UTF-8 encoder: classify, pack and serialize stages.
// Depends on u8e_pkg, u8e_classify, u8e_pack, u8e_serial and the assert header.
//
// Each input beat is one character; the block emits its RFC 2279 UTF-8 bytes,
// lead byte first, one byte per output beat with tlast on the final byte.
// Code points above 0x7fffffff and characters flagged as non-Unicode give a
// single space. The first byte comes out after the classify, pack and serial
// registers take the beat. The output stage sends one byte per cycle while
// m_tready is high; an n-byte character holds it, and in steady state the input,
// until its last byte is taken. Single-byte characters flow at one per cycle.
`include "utf8_encoder_six_byte_top_assert.svh"
module utf8_encoder_six_byte_top
    import u8e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // code_point[31:0]
    input  logic        s_tuser,   // is_unicode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    logic  cls_valid;
    logic  cls_ready;
    char_t cls_char;
    logic  pk_valid;
    logic  pk_ready;
    seq_t  pk_seq;

    u8e_classify u_classify (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .code_point (s_tdata),
        .is_unicode (s_tuser),
        .out_valid  (cls_valid),
        .out_ready  (cls_ready),
        .out_char   (cls_char)
    );

    u8e_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cls_valid),
        .in_ready  (cls_ready),
        .in_char   (cls_char),
        .out_valid (pk_valid),
        .out_ready (pk_ready),
        .out_seq   (pk_seq)
    );

    u8e_serial u_serial (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pk_valid),
        .in_ready (pk_ready),
        .in_seq   (pk_seq),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `U8E_ASSERT_IMP(a_multi_high_bits, m_tvalid && !m_tlast, m_tdata[7])
    `U8E_ASSERT_NEXT(a_cont_follows, m_tvalid && m_tready && !m_tlast,
        m_tvalid && m_tdata[7:6] == CONT_MARK)
    `U8E_ASSERT_IMP(a_space_single, m_tvalid && m_tdata == SPACE_BYTE, m_tlast)

endmodule

// ===== rtl/u8e_classify.sv =====
// First stage: registers the incoming character with its sequence length.
// Depends on u8e_pkg.
module u8e_classify
    import u8e_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] code_point,
    input  logic        is_unicode,
    output logic        out_valid,
    input  logic        out_ready,
    output char_t       out_char
);

    logic  valid_reg;
    char_t char_reg;
    char_t char_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_char  = char_reg;

    always_comb
    begin
        char_next.cp    = code_point[30:0];
        char_next.space = !is_unicode || code_point[31];
        if (char_next.space || code_point <= MAX_LEN1)
        begin
            char_next.len = LEN1;
        end
        else if (code_point <= MAX_LEN2)
        begin
            char_next.len = LEN2;
        end
        else if (code_point <= MAX_LEN3)
        begin
            char_next.len = LEN3;
        end
        else if (code_point <= MAX_LEN4)
        begin
            char_next.len = LEN4;
        end
        else if (code_point <= MAX_LEN5)
        begin
            char_next.len = LEN5;
        end
        else
        begin
            char_next.len = LEN6;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            char_reg <= char_next;
        end
    end

endmodule

// ===== rtl/u8e_pack.sv =====
// Second stage: builds the byte sequence, lead byte in the top byte.
// Depends on u8e_pkg.
module u8e_pack
    import u8e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  char_t in_char,
    output logic  out_valid,
    input  logic  out_ready,
    output seq_t  out_seq
);

    logic valid_reg;
    seq_t seq_reg;
    seq_t seq_next;

    function automatic logic [7:0] cont(input logic [5:0] bits);
        cont = {CONT_MARK, bits};
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_seq   = seq_reg;

    always_comb
    begin
        seq_next.len = in_char.len;
        if (in_char.space)
        begin
            seq_next.seq = {SPACE_BYTE, 40'h0};
        end
        else
        begin
            case (in_char.len)
                LEN2: seq_next.seq = {LEAD2 | {3'b000, in_char.cp[10:6]},
                                      cont(in_char.cp[5:0]), 32'h0};
                LEN3: seq_next.seq = {LEAD3 | {4'b0000, in_char.cp[15:12]},
                                      cont(in_char.cp[11:6]), cont(in_char.cp[5:0]),
                                      24'h0};
                LEN4: seq_next.seq = {LEAD4 | {5'b00000, in_char.cp[20:18]},
                                      cont(in_char.cp[17:12]), cont(in_char.cp[11:6]),
                                      cont(in_char.cp[5:0]), 16'h0};
                LEN5: seq_next.seq = {LEAD5 | {6'b000000, in_char.cp[25:24]},
                                      cont(in_char.cp[23:18]), cont(in_char.cp[17:12]),
                                      cont(in_char.cp[11:6]), cont(in_char.cp[5:0]),
                                      8'h0};
                LEN6: seq_next.seq = {LEAD6 | {7'b0000000, in_char.cp[30]},
                                      cont(in_char.cp[29:24]), cont(in_char.cp[23:18]),
                                      cont(in_char.cp[17:12]), cont(in_char.cp[11:6]),
                                      cont(in_char.cp[5:0])};
                default: seq_next.seq = {1'b0, in_char.cp[6:0], 40'h0};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            seq_reg <= seq_next;
        end
    end

endmodule

// ===== rtl/u8e_serial.sv =====
// Output stage: shifts out one byte per beat, marking the final byte.
// Depends on u8e_pkg.
module u8e_serial
    import u8e_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  seq_t       in_seq,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [SEQ_W-1:0] buf_reg;
    logic [SEQ_W-1:0] buf_next;
    len_t             cnt_reg;
    len_t             cnt_next;

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = buf_reg[SEQ_W-1 -: 8];
    assign m_tlast  = (cnt_reg == LEN1);
    assign in_ready = (cnt_reg == '0) || (m_tlast && m_tready);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (in_ready)
        begin
            buf_next = in_seq.seq;
            cnt_next = in_valid ? in_seq.len : '0;
        end
        else if (m_tready)
        begin
            buf_next = {buf_reg[SEQ_W-9:0], 8'h00};
            cnt_next = cnt_reg - LEN1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule
